// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clk edge outside reset.
`define ASSERT_AT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== design/bcdcal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bcdcal_pkg;

  localparam logic [31:0] SECS_PER_DAY = 32'd86400;
  localparam logic [6:0]  EPOCH_YY     = 7'd70;
  localparam logic [4:0]  EPOCH_CENT   = 5'd19;
  localparam logic [15:0] EPOCH_WDAY   = 16'd4;

  // Reciprocals for the constant divisions, floor(x / d) = (x * R) >> k:
  // (e >> 7) / 675 with k = 35, (tod >> 2) / 15 and (min >> 2) / 15 with
  // k = 19 and k = 13, and (days + 4) / 7 with k = 19.
  localparam logic [25:0] RECIP_DAY  = 26'd50903317;
  localparam logic [15:0] RECIP_MIN  = 16'd34953;
  localparam logic [9:0]  RECIP_HR   = 10'd547;
  localparam logic [16:0] RECIP_WDAY = 17'd74899;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_SKIPPED = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    DIV_DAY  = 2'd0,
    DIV_SEC  = 2'd1,
    DIV_MIN  = 2'd2,
    DIV_WDAY = 2'd3
  } divsel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_LOAD,
    S_DIV_RUN,
    S_YEAR_INIT,
    S_YEAR,
    S_MONTH,
    S_EPOCH,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic    load;
    logic    div_load;
    logic    div_step;
    divsel_t div_sel;
    logic    year_init;
    logic    year_step;
    logic    month_step;
    logic    epoch_calc;
    logic    emit;
    stat_t   status;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } sts_t;

  function automatic logic is_leap(input logic [6:0] yy, input logic [4:0] cent);
    return (yy[1:0] == 2'd0) && ((yy != 7'd0) || (cent[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m) inside
      4'd1:                      n = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] bcd_dec(input logic [7:0] v);
    return 8'({4'b0, v[7:4]} * 8'd10 + {4'b0, v[3:0]});
  endfunction

  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [7:0] b;
    int         i;
    b = '0;
    for (i = 6; i >= 0; i--) begin
      if (b[3:0] >= 4'd5) b[3:0] = b[3:0] + 4'd3;
      if (b[7:4] >= 4'd5) b[7:4] = b[7:4] + 4'd3;
      b = {b[6:0], v[i]};
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== design/bcdcal_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bcdcal_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             operation,
  input  wire logic             clock_valid,
  input  bcdcal_pkg::sts_t      sts,
  output bcdcal_pkg::cmd_t      cmd,
  output logic                  busy
);
  import bcdcal_pkg::*;

  state_t     state_r, state_nxt;
  divsel_t    divsel_r, divsel_nxt;
  logic       op_r, op_nxt;
  logic       tws_r, tws_nxt;
  stat_t      stat_r, stat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      divsel_r <= DIV_DAY;
      op_r     <= 1'b0;
      tws_r    <= 1'b0;
      stat_r   <= STAT_DONE;
    end else begin
      state_r  <= state_nxt;
      divsel_r <= divsel_nxt;
      op_r     <= op_nxt;
      tws_r    <= tws_nxt;
      stat_r   <= stat_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    divsel_nxt = divsel_r;
    op_nxt     = op_r;
    tws_nxt    = tws_r;
    stat_nxt   = stat_r;
    cmd        = '0;
    cmd.status = stat_r;
    cmd.div_sel = divsel_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          op_nxt   = operation;
          if (!operation) begin
            tws_nxt = 1'b1;
            if (clock_valid) begin
              stat_nxt  = STAT_DONE;
              state_nxt = S_YEAR_INIT;
            end else begin
              stat_nxt  = STAT_INVALID;
              state_nxt = S_EMIT;
            end
          end else if (!tws_r) begin
            stat_nxt  = STAT_SKIPPED;
            state_nxt = S_EMIT;
          end else begin
            stat_nxt   = STAT_DONE;
            divsel_nxt = DIV_DAY;
            state_nxt  = S_DIV_LOAD;
          end
        end
      end
      S_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (divsel_r == DIV_WDAY) begin
          state_nxt = S_YEAR_INIT;
        end else begin
          divsel_nxt = divsel_t'(divsel_r + 2'd1);
          state_nxt  = S_DIV_LOAD;
        end
      end
      S_YEAR_INIT: begin
        cmd.year_init = 1'b1;
        state_nxt     = S_YEAR;
      end
      S_YEAR: begin
        if (sts.year_done) begin
          state_nxt = S_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      S_MONTH: begin
        if (sts.month_done) begin
          state_nxt = op_r ? S_EMIT : S_EPOCH;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      S_EPOCH: begin
        cmd.epoch_calc = 1'b1;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ===== design/bcdcal_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bcdcal_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  bcdcal_pkg::cmd_t       cmd,
  output bcdcal_pkg::sts_t       sts,
  input  wire logic              operation,
  input  wire logic [31:0]       epoch_seconds_in,
  input  wire logic [7:0]        bcd_second_in,
  input  wire logic [7:0]        bcd_minute_in,
  input  wire logic [7:0]        bcd_hour_in,
  input  wire logic [7:0]        bcd_day_in,
  input  wire logic [7:0]        bcd_month_in,
  input  wire logic [7:0]        bcd_year_in,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [31:0]            out_epoch_seconds_out,
  output logic [6:0]             out_bcd_second_out,
  output logic [6:0]             out_bcd_minute_out,
  output logic [5:0]             out_bcd_hour_out,
  output logic [2:0]             out_weekday,
  output logic [5:0]             out_bcd_day_out,
  output logic [4:0]             out_bcd_month_out,
  output logic [7:0]             out_bcd_year_out
);
  import bcdcal_pkg::*;

  logic        op_r;
  logic [31:0] e_r;
  logic [7:0]  sec_r, min_r, hr_r, dom_r;
  logic [3:0]  mon_r;
  logic [6:0]  tgt_yy_r;
  logic [4:0]  tgt_cent_r;
  logic [16:0] rem_r;
  logic [10:0] mt_r;
  logic [15:0] wq_r;
  logic [15:0] days_r;
  logic [2:0]  wday_r;
  logic [6:0]  yy_r;
  logic [4:0]  cent_r;
  logic [3:0]  m_r;
  logic [19:0] tod_r;
  logic [31:0] prod_r;
  logic        valid_r;
  stat_t       status_r;
  logic [31:0] epoch_r;
  logic [6:0]  osec_r, omin_r;
  logic [5:0]  ohr_r, oday_r;
  logic [4:0]  omon_r;
  logic [7:0]  oyear_r;
  logic [2:0]  owday_r;

  logic [7:0]  yr_dec, mon_dec;
  logic [3:0]  mon_clamp;
  logic [50:0] day_prod;
  logic [30:0] min_prod;
  logic [19:0] hr_prod;
  logic [15:0] wsum;
  logic [32:0] wk_prod;
  logic        leap;
  logic [8:0]  yl;
  logic [4:0]  dim;
  logic [31:0] dayterm;
  logic [7:0]  bcd_sec, bcd_min, bcd_hr, bcd_day, bcd_mon, bcd_yr;

  always_comb begin
    yr_dec  = bcd_dec(bcd_year_in);
    mon_dec = bcd_dec(bcd_month_in);
    if (mon_dec == 8'd0) begin
      mon_clamp = 4'd1;
    end else if (mon_dec > 8'd12) begin
      mon_clamp = 4'd12;
    end else begin
      mon_clamp = mon_dec[3:0];
    end
  end

  assign day_prod = 51'(e_r[31:7]) * 51'(RECIP_DAY);
  assign min_prod = 31'(rem_r[16:2]) * 31'(RECIP_MIN);
  assign hr_prod  = 20'(mt_r[10:2]) * 20'(RECIP_HR);
  assign wsum     = days_r + EPOCH_WDAY;
  assign wk_prod  = 33'(wsum) * 33'(RECIP_WDAY);

  assign leap    = is_leap(yy_r, cent_r);
  assign yl      = leap ? 9'd366 : 9'd365;
  assign dim     = month_len(m_r, leap);
  assign dayterm = 32'(days_r) + 32'(dom_r) - 32'd1;

  assign sts.year_done = op_r ? (days_r < 16'(yl))
                              : ((yy_r == tgt_yy_r) && (cent_r == tgt_cent_r));
  assign sts.month_done = op_r ? ((m_r == 4'd11) || (days_r < 16'(dim)))
                               : (({1'b0, m_r} + 5'd1) >= {1'b0, mon_r});

  assign bcd_sec = to_bcd(sec_r[6:0]);
  assign bcd_min = to_bcd(min_r[6:0]);
  assign bcd_hr  = to_bcd(hr_r[6:0]);
  assign bcd_day = to_bcd(7'(days_r[4:0]) + 7'd1);
  assign bcd_mon = to_bcd({3'b0, m_r} + 7'd1);
  assign bcd_yr  = to_bcd(yy_r);

  always_ff @(posedge clk) begin
    tod_r <= 20'(sec_r) + 20'(min_r) * 20'd60 + 20'(hr_r) * 20'd3600;

    if (cmd.load) begin
      op_r  <= operation;
      e_r   <= epoch_seconds_in;
      sec_r <= bcd_dec(bcd_second_in);
      min_r <= bcd_dec(bcd_minute_in);
      hr_r  <= bcd_dec(bcd_hour_in);
      dom_r <= bcd_dec(bcd_day_in);
      mon_r <= mon_clamp;
      if (yr_dec < 8'd70) begin
        tgt_cent_r <= 5'd20;
        tgt_yy_r   <= yr_dec[6:0];
      end else if (yr_dec < 8'd100) begin
        tgt_cent_r <= 5'd19;
        tgt_yy_r   <= yr_dec[6:0];
      end else begin
        tgt_cent_r <= 5'd20;
        tgt_yy_r   <= 7'(yr_dec - 8'd100);
      end
    end

    // Load takes the quotient, step takes the remainder.
    if (cmd.div_load) begin
      case (cmd.div_sel)
        DIV_DAY: begin
          days_r <= 16'(day_prod >> 35);
        end
        DIV_SEC: begin
          mt_r <= 11'(min_prod >> 19);
        end
        DIV_MIN: begin
          hr_r <= 8'(hr_prod >> 13);
        end
        default: begin
          wq_r <= 16'(wk_prod >> 19);
        end
      endcase
    end else if (cmd.div_step) begin
      case (cmd.div_sel)
        DIV_DAY: begin
          rem_r <= 17'(e_r - 32'(days_r) * SECS_PER_DAY);
        end
        DIV_SEC: begin
          sec_r <= 8'(rem_r - 17'(mt_r) * 17'd60);
        end
        DIV_MIN: begin
          min_r <= 8'(mt_r - 11'(hr_r) * 11'd60);
        end
        default: begin
          wday_r <= 3'(wsum - wq_r * 16'd7);
        end
      endcase
    end

    if (cmd.year_init) begin
      yy_r   <= EPOCH_YY;
      cent_r <= EPOCH_CENT;
      m_r    <= '0;
      if (!op_r) days_r <= '0;
    end else if (cmd.year_step) begin
      days_r <= op_r ? (days_r - 16'(yl)) : (days_r + 16'(yl));
      if (yy_r == 7'd99) begin
        yy_r   <= '0;
        cent_r <= cent_r + 5'd1;
      end else begin
        yy_r <= yy_r + 7'd1;
      end
    end else if (cmd.month_step) begin
      days_r <= op_r ? (days_r - 16'(dim)) : (days_r + 16'(dim));
      m_r    <= m_r + 4'd1;
    end

    if (cmd.epoch_calc) begin
      prod_r <= dayterm * SECS_PER_DAY;
    end

    if (cmd.emit) begin
      status_r <= cmd.status;
      if ((cmd.status == STAT_DONE) && !op_r) begin
        epoch_r <= prod_r + 32'(tod_r);
      end else begin
        epoch_r <= '0;
      end
      if ((cmd.status == STAT_DONE) && op_r) begin
        osec_r  <= bcd_sec[6:0];
        omin_r  <= bcd_min[6:0];
        ohr_r   <= bcd_hr[5:0];
        owday_r <= wday_r;
        oday_r  <= bcd_day[5:0];
        omon_r  <= bcd_mon[4:0];
        oyear_r <= bcd_yr;
      end else begin
        osec_r  <= '0;
        omin_r  <= '0;
        ohr_r   <= '0;
        owday_r <= '0;
        oday_r  <= '0;
        omon_r  <= '0;
        oyear_r <= '0;
      end
    end

    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
    end
  end

  assign out_valid             = valid_r;
  assign out_status            = status_r;
  assign out_epoch_seconds_out = epoch_r;
  assign out_bcd_second_out    = osec_r;
  assign out_bcd_minute_out    = omin_r;
  assign out_bcd_hour_out      = ohr_r;
  assign out_weekday           = owday_r;
  assign out_bcd_day_out       = oday_r;
  assign out_bcd_month_out     = omon_r;
  assign out_bcd_year_out      = oyear_r;

endmodule

`default_nettype wire

// ===== design/bcd_calendar_epoch_converter.sv =====
// Clock-invalid or skipped beats go straight to emit. BCD to epoch runs year walk, one
// year a cycle, then month walk and epoch product. Epoch to BCD runs the reciprocal split
// (day, second, minute and weekday divisions, each a load then a remainder step), then
// year and month walk. One beat in flight; busy stays high until the result is out.
// out_valid pulses for one cycle per beat; the receiver cannot stall.
// Synchronous active-low reset returns to idle and clears the time-set flag.
`timescale 1ns / 1ps
`default_nettype none

module bcd_calendar_epoch_converter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_operation,
  input  wire logic [31:0] in_epoch_seconds_in,
  input  wire logic        in_clock_valid,
  input  wire logic [7:0]  in_bcd_second_in,
  input  wire logic [7:0]  in_bcd_minute_in,
  input  wire logic [7:0]  in_bcd_hour_in,
  input  wire logic [7:0]  in_bcd_day_in,
  input  wire logic [7:0]  in_bcd_month_in,
  input  wire logic [7:0]  in_bcd_year_in,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_epoch_seconds_out,
  output logic [6:0]       out_bcd_second_out,
  output logic [6:0]       out_bcd_minute_out,
  output logic [5:0]       out_bcd_hour_out,
  output logic [2:0]       out_weekday,
  output logic [5:0]       out_bcd_day_out,
  output logic [4:0]       out_bcd_month_out,
  output logic [7:0]       out_bcd_year_out
);
  import bcdcal_pkg::*;

  `include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;

  bcdcal_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .operation   (in_operation),
    .clock_valid (in_clock_valid),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  bcdcal_datapath u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .operation             (in_operation),
    .epoch_seconds_in      (in_epoch_seconds_in),
    .bcd_second_in         (in_bcd_second_in),
    .bcd_minute_in         (in_bcd_minute_in),
    .bcd_hour_in           (in_bcd_hour_in),
    .bcd_day_in            (in_bcd_day_in),
    .bcd_month_in          (in_bcd_month_in),
    .bcd_year_in           (in_bcd_year_in),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_epoch_seconds_out (out_epoch_seconds_out),
    .out_bcd_second_out    (out_bcd_second_out),
    .out_bcd_minute_out    (out_bcd_minute_out),
    .out_bcd_hour_out      (out_bcd_hour_out),
    .out_weekday           (out_weekday),
    .out_bcd_day_out       (out_bcd_day_out),
    .out_bcd_month_out     (out_bcd_month_out),
    .out_bcd_year_out      (out_bcd_year_out)
  );

  `ASSERT_AT_CLK(a_strobe_idle, out_valid |-> !busy, "result beat while busy")
  `ASSERT_AT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted beat left block idle")
  `ASSERT_AT_CLK(a_strobe_single, out_valid |=> !out_valid, "result strobe held twice")
  `ASSERT_NEVER(a_epoch_zero, out_valid && (out_status != STAT_DONE) && (|out_epoch_seconds_out), "epoch on failed beat")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bcdcal_pkg::stat_t;
  import bcdcal_pkg::STAT_DONE;
  import bcdcal_pkg::STAT_INVALID;
  import bcdcal_pkg::STAT_SKIPPED;

  localparam logic        OP_TO_EPOCH = 1'b0;
  localparam logic        OP_TO_BCD   = 1'b1;
  localparam int unsigned DAY_SECS    = 86400;
  localparam int unsigned BASE_YEAR   = 1970;
  localparam int          RAND_BEATS  = 750;
  localparam int          TAIL_CYCLES = 300;

  typedef struct packed {
    logic        op;
    logic [31:0] epoch;
    logic        cv;
    logic [7:0]  sec;
    logic [7:0]  min;
    logic [7:0]  hour;
    logic [7:0]  day;
    logic [7:0]  mon;
    logic [7:0]  year;
  } cal_in_t;

  typedef struct packed {
    stat_t       status;
    logic [31:0] epoch;
    logic [6:0]  sec;
    logic [6:0]  min;
    logic [5:0]  hour;
    logic [2:0]  wday;
    logic [5:0]  day;
    logic [4:0]  mon;
    logic [7:0]  year;
  } cal_out_t;

  typedef struct {
    cal_in_t  stim;
    bit       typed;
    cal_out_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_operation = 1'b0;
  logic [31:0] in_epoch_seconds_in = '0;
  logic in_clock_valid = 1'b0;
  logic [7:0] in_bcd_second_in = '0;
  logic [7:0] in_bcd_minute_in = '0;
  logic [7:0] in_bcd_hour_in = '0;
  logic [7:0] in_bcd_day_in = '0;
  logic [7:0] in_bcd_month_in = '0;
  logic [7:0] in_bcd_year_in = '0;

  wire logic        busy;
  wire logic        out_valid;
  wire logic [1:0]  out_status;
  wire logic [31:0] out_epoch_seconds_out;
  wire logic [6:0]  out_bcd_second_out;
  wire logic [6:0]  out_bcd_minute_out;
  wire logic [5:0]  out_bcd_hour_out;
  wire logic [2:0]  out_weekday;
  wire logic [5:0]  out_bcd_day_out;
  wire logic [4:0]  out_bcd_month_out;
  wire logic [7:0]  out_bcd_year_out;

  bcd_calendar_epoch_converter dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_operation          (in_operation),
    .in_epoch_seconds_in   (in_epoch_seconds_in),
    .in_clock_valid        (in_clock_valid),
    .in_bcd_second_in      (in_bcd_second_in),
    .in_bcd_minute_in      (in_bcd_minute_in),
    .in_bcd_hour_in        (in_bcd_hour_in),
    .in_bcd_day_in         (in_bcd_day_in),
    .in_bcd_month_in       (in_bcd_month_in),
    .in_bcd_year_in        (in_bcd_year_in),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_epoch_seconds_out (out_epoch_seconds_out),
    .out_bcd_second_out    (out_bcd_second_out),
    .out_bcd_minute_out    (out_bcd_minute_out),
    .out_bcd_hour_out      (out_bcd_hour_out),
    .out_weekday           (out_weekday),
    .out_bcd_day_out       (out_bcd_day_out),
    .out_bcd_month_out     (out_bcd_month_out),
    .out_bcd_year_out      (out_bcd_year_out)
  );

  cal_out_t due_results[$];
  dir_row_t dir_tab[$];
  bit       clock_set = 1'b0;
  bit       quiet = 1'b0;
  int       errors = 0;
  cal_out_t seen_beat;
  cal_out_t due_beat;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned year_days(input int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  function automatic int unsigned month_days(input int unsigned m0, input bit leap);
    int unsigned n;
    case (m0 % 12)
      1:             n = leap ? 29 : 28;
      3, 5, 8, 10:   n = 30;
      default:       n = 31;
    endcase
    return n;
  endfunction

  function automatic int unsigned from_bcd(input logic [7:0] v);
    int unsigned hi;
    int unsigned lo;
    hi = v[7:4];
    lo = v[3:0];
    return hi * 10 + lo;
  endfunction

  function automatic logic [7:0] to_bcd_byte(input int unsigned v);
    int unsigned r;
    r = v % 100;
    return {4'(r / 10), 4'(r % 10)};
  endfunction

  function automatic cal_out_t epoch_result(input stat_t st, input logic [31:0] e);
    cal_out_t r;
    r = '0;
    r.status = st;
    r.epoch = e;
    return r;
  endfunction

  function automatic cal_out_t date_result(input logic [7:0] s, input logic [7:0] mi,
                                           input logic [7:0] h, input logic [2:0] wd,
                                           input logic [7:0] d, input logic [7:0] mo,
                                           input logic [7:0] y);
    cal_out_t r;
    r = '0;
    r.status = STAT_DONE;
    r.sec = s[6:0];
    r.min = mi[6:0];
    r.hour = h[5:0];
    r.wday = wd;
    r.day = d[5:0];
    r.mon = mo[4:0];
    r.year = y;
    return r;
  endfunction

  function automatic cal_in_t to_epoch_beat(input logic cv, input logic [7:0] s,
                                            input logic [7:0] mi, input logic [7:0] h,
                                            input logic [7:0] d, input logic [7:0] mo,
                                            input logic [7:0] y);
    cal_in_t b;
    b.op = OP_TO_EPOCH;
    b.epoch = $urandom;
    b.cv = cv;
    b.sec = s;
    b.min = mi;
    b.hour = h;
    b.day = d;
    b.mon = mo;
    b.year = y;
    return b;
  endfunction

  function automatic cal_in_t to_bcd_beat(input logic [31:0] e);
    cal_in_t b;
    b.op = OP_TO_BCD;
    b.epoch = e;
    b.cv = 1'($urandom);
    b.sec = 8'($urandom);
    b.min = 8'($urandom);
    b.hour = 8'($urandom);
    b.day = 8'($urandom);
    b.mon = 8'($urandom);
    b.year = 8'($urandom);
    return b;
  endfunction

  function automatic cal_out_t predict_calendar(input cal_in_t b);
    int unsigned s, mi, h, d, mo, yy, full, days, n, e, tod, y, m, wd;
    bit leap;
    if (b.op == OP_TO_EPOCH) begin
      clock_set = 1'b1;
      if (!b.cv) return epoch_result(STAT_INVALID, '0);
      s = from_bcd(b.sec);
      mi = from_bcd(b.min);
      h = from_bcd(b.hour);
      d = from_bcd(b.day);
      mo = from_bcd(b.mon);
      yy = from_bcd(b.year);
      if (yy < 70) yy += 100;
      if (mo < 1) mo = 1;
      if (mo > 12) mo = 12;
      full = 1900 + yy;
      leap = leap_year(full);
      days = 0;
      for (m = 0; m + 1 < mo; m++) days += month_days(m, leap);
      for (y = BASE_YEAR; y < full; y++) days += year_days(y);
      n = s + 60 * mi + 3600 * h + (d - 1) * DAY_SECS + days * DAY_SECS;
      return epoch_result(STAT_DONE, n);
    end
    if (!clock_set) return epoch_result(STAT_SKIPPED, '0);
    e = b.epoch;
    tod = e % DAY_SECS;
    days = e / DAY_SECS;
    wd = (days + 4) % 7;
    y = BASE_YEAR;
    while (days >= year_days(y)) begin
      days -= year_days(y);
      y++;
    end
    leap = leap_year(y);
    m = 0;
    while (m < 11 && days >= month_days(m, leap)) begin
      days -= month_days(m, leap);
      m++;
    end
    return date_result(to_bcd_byte(tod % 60), to_bcd_byte((tod / 60) % 60),
                       to_bcd_byte(tod / 3600), 3'(wd), to_bcd_byte(days + 1),
                       to_bcd_byte(m + 1), to_bcd_byte(y % 100));
  endfunction

  function automatic cal_in_t random_beat();
    int unsigned sel, yy, full, mo, e;
    if ($urandom_range(0, 1) == 0) begin
      sel = $urandom_range(0, 9);
      if (sel < 8) begin
        yy = $urandom_range(0, 99);
        full = (yy < 70) ? 2000 + yy : 1900 + yy;
        mo = $urandom_range(1, 12);
        return to_epoch_beat($urandom_range(0, 9) != 0,
                             to_bcd_byte($urandom_range(0, 59)),
                             to_bcd_byte($urandom_range(0, 59)),
                             to_bcd_byte($urandom_range(0, 23)),
                             to_bcd_byte($urandom_range(1, month_days(mo - 1, leap_year(full)))),
                             to_bcd_byte(mo), to_bcd_byte(yy));
      end
      return to_epoch_beat($urandom_range(0, 9) != 0, 8'($urandom), 8'($urandom),
                           8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
    sel = $urandom_range(0, 9);
    case (sel)
      4, 5:    e = ($urandom % 49710) * DAY_SECS + ($urandom_range(0, 1) ? 0 : DAY_SECS - 1);
      6:       e = $urandom_range(0, DAY_SECS * 800);
      7:       e = $urandom_range(32'hF000_0000, 32'hFFFF_FFFF);
      default: e = $urandom;
    endcase
    return to_bcd_beat(e);
  endfunction

  task automatic send_calendar_beat(input cal_in_t b, input bit typed, input cal_out_t want);
    cal_out_t exp_beat;
    if (!quiet && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 250)) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= b.op;
    in_epoch_seconds_in <= b.epoch;
    in_clock_valid <= b.cv;
    in_bcd_second_in <= b.sec;
    in_bcd_minute_in <= b.min;
    in_bcd_hour_in <= b.hour;
    in_bcd_day_in <= b.day;
    in_bcd_month_in <= b.mon;
    in_bcd_year_in <= b.year;
    do @(posedge clk); while (busy);
    exp_beat = predict_calendar(b);
    if (typed) exp_beat = want;
    due_results.push_back(exp_beat);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      seen_beat.status = stat_t'(out_status);
      seen_beat.epoch = out_epoch_seconds_out;
      seen_beat.sec = out_bcd_second_out;
      seen_beat.min = out_bcd_minute_out;
      seen_beat.hour = out_bcd_hour_out;
      seen_beat.wday = out_weekday;
      seen_beat.day = out_bcd_day_out;
      seen_beat.mon = out_bcd_month_out;
      seen_beat.year = out_bcd_year_out;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result beat with nothing pending: %p", seen_beat);
      end else begin
        due_beat = due_results.pop_front();
        if (seen_beat.status !== due_beat.status || seen_beat.epoch !== due_beat.epoch ||
            seen_beat.sec !== due_beat.sec || seen_beat.min !== due_beat.min ||
            seen_beat.hour !== due_beat.hour || seen_beat.wday !== due_beat.wday ||
            seen_beat.day !== due_beat.day || seen_beat.mon !== due_beat.mon ||
            seen_beat.year !== due_beat.year) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", due_beat, seen_beat);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("** bcd_calendar_epoch_converter: FAILED **");
    $finish;
  end

  initial begin
    dir_tab.push_back('{to_bcd_beat(32'd0), 1'b1, epoch_result(STAT_SKIPPED, '0)});
    dir_tab.push_back('{to_bcd_beat(32'hFFFF_FFFF), 1'b1, epoch_result(STAT_SKIPPED, '0)});
    dir_tab.push_back('{to_epoch_beat(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                        1'b1, epoch_result(STAT_INVALID, '0)});
    dir_tab.push_back('{to_bcd_beat(32'd0), 1'b1,
                        date_result(8'h00, 8'h00, 8'h00, 3'd4, 8'h01, 8'h01, 8'h70)});
    dir_tab.push_back('{to_epoch_beat(1'b1, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70),
                        1'b1, epoch_result(STAT_DONE, 32'd0)});
    dir_tab.push_back('{to_epoch_beat(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h70),
                        1'b1, epoch_result(STAT_DONE, 32'hFFFE_AE80)});
    dir_tab.push_back('{to_bcd_beat(32'hFFFF_FFFF), 1'b1,
                        date_result(8'h15, 8'h28, 8'h06, 3'd0, 8'h07, 8'h02, 8'h06)});
    dir_tab.push_back('{to_epoch_beat(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                        1'b0, '0});
    dir_tab.push_back('{to_epoch_beat(1'b1, 8'h30, 8'h45, 8'h12, 8'h15, 8'h00, 8'h24),
                        1'b0, '0});
    dir_tab.push_back('{to_epoch_beat(1'b1, 8'h30, 8'h45, 8'h12, 8'h15, 8'h13, 8'h88),
                        1'b0, '0});
    dir_tab.push_back('{to_epoch_beat(1'b1, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69),
                        1'b0, '0});
    dir_tab.push_back('{to_epoch_beat(1'b1, 8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00),
                        1'b0, '0});
    dir_tab.push_back('{to_epoch_beat(1'b1, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99),
                        1'b0, '0});
    dir_tab.push_back('{to_epoch_beat(1'b1, 8'h99, 8'h99, 8'h99, 8'h01, 8'h01, 8'h70),
                        1'b0, '0});
    dir_tab.push_back('{to_epoch_beat(1'b1, 8'hAF, 8'hFA, 8'h3C, 8'hC3, 8'h0B, 8'hA5),
                        1'b0, '0});
    dir_tab.push_back('{to_epoch_beat(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                        1'b0, '0});
    dir_tab.push_back('{to_bcd_beat(32'd951782400), 1'b0, '0});
    dir_tab.push_back('{to_bcd_beat(32'd4107542400), 1'b0, '0});
    dir_tab.push_back('{to_bcd_beat(32'd86399), 1'b0, '0});
    dir_tab.push_back('{to_bcd_beat(32'd3155759999), 1'b0, '0});
    dir_tab.push_back('{to_bcd_beat(32'h7FFF_FFFF), 1'b0, '0});
    dir_tab.push_back('{to_epoch_beat(1'b0, 8'h12, 8'h34, 8'h05, 8'h17, 8'h06, 8'h21),
                        1'b1, epoch_result(STAT_INVALID, '0)});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_calendar_beat(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);

    for (int i = 0; i < RAND_BEATS; i++) begin
      quiet = (i >= 400 && i < 550);
      if (i == 250) begin
        start <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
      end
      send_calendar_beat(random_beat(), 1'b0, '0);
    end
    start <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && due_results.size() == 0) begin
      $display("** bcd_calendar_epoch_converter: PASSED **");
    end else begin
      $display("** bcd_calendar_epoch_converter: FAILED **");
    end
    $finish;
  end

endmodule
